// ===== hw/rtl/npfp_pkg.sv =====
// ============================================================================
// npfp_pkg
// Shared types, character codes and helper functions for the position
// sentence field parser.
// ============================================================================
`default_nettype none

package npfp_pkg;

	// Payload widths
	localparam int unsigned CHAR_W = 8;
	localparam int unsigned LAT_W  = 27;
	localparam int unsigned LON_W  = 28;
	localparam int unsigned MIN_W  = 20;
	localparam int unsigned DEG_W  = 8;
	localparam int unsigned CIF_W  = 4;
	localparam int unsigned FC_W   = 3;
	localparam int unsigned FLD_W  = 3;

	// Saturation limits
	localparam logic [DEG_W-1:0]   DEG_MAX     = '1;
	localparam logic [MIN_W-1:0]   MIN_MAX     = '1;
	localparam logic [LAT_W-2:0]   LAT_MAG_MAX = '1;
	localparam logic [LON_W-2:0]   LON_MAG_MAX = '1;
	localparam logic [CIF_W-1:0]   CIF_MAX     = '1;
	localparam logic [FLD_W-1:0]   FIELD_MAX   = '1;

	// ASCII codes
	localparam logic [CHAR_W-1:0] CHAR_COMMA = 8'h2C;
	localparam logic [CHAR_W-1:0] CHAR_POINT = 8'h2E;
	localparam logic [CHAR_W-1:0] CHAR_0     = 8'h30;
	localparam logic [CHAR_W-1:0] CHAR_9     = 8'h39;
	localparam logic [CHAR_W-1:0] CHAR_N     = 8'h4E;
	localparam logic [CHAR_W-1:0] CHAR_T     = 8'h54;
	localparam logic [CHAR_W-1:0] CHAR_S     = 8'h53;
	localparam logic [CHAR_W-1:0] CHAR_W_UP  = 8'h57;

	// Field numbers within a sentence
	localparam logic [FLD_W-1:0] FIELD_LAT      = 3'd1;
	localparam logic [FLD_W-1:0] FIELD_LAT_SIGN = 3'd2;
	localparam logic [FLD_W-1:0] FIELD_LON      = 3'd3;
	localparam logic [FLD_W-1:0] FIELD_LON_SIGN = 3'd4;

	// Degree digits at the head of each coordinate field
	localparam logic [CIF_W-1:0] LAT_DEG_DIGITS = 4'd2;
	localparam logic [CIF_W-1:0] LON_DEG_DIGITS = 4'd3;

	// Fail cause codes
	typedef enum logic [1:0] {
		FAIL_NONE  = 2'd0,
		FAIL_START = 2'd1,
		FAIL_TEXT  = 2'd2,
		FAIL_FIELD = 2'd3
	} fail_cause_t;

	// Power of ten at elaboration time
	function automatic longint unsigned pow10(input int unsigned n);
		longint unsigned p;
		p = 1;
		for (int unsigned i = 0; i < n && i < 12; i++) begin
			p = p * 10;
		end
		return p;
	endfunction

	// Power of ten for the zero padding of missing fraction digits
	function automatic logic [MIN_W-1:0] pow10_small(input logic [FC_W-1:0] n);
		logic [MIN_W-1:0] p;
		unique case (n)
			3'd0:    p = 20'd1;
			3'd1:    p = 20'd10;
			3'd2:    p = 20'd100;
			3'd3:    p = 20'd1000;
			3'd4:    p = 20'd10000;
			3'd5:    p = 20'd100000;
			3'd6:    p = 20'd1000000;
			default: p = 20'd1;
		endcase
		return p;
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/npfp_if.sv =====
// ============================================================================
// npfp_if
// Valid/ready channels of the position sentence field parser: the character
// beat stream in and the position result out.
// ============================================================================
`default_nettype none

interface npfp_char_if;
	logic                           valid;
	logic                           ready;
	logic [npfp_pkg::CHAR_W-1:0]    data_byte;
	logic                           first_byte;
	logic                           last_byte;

	modport source (output valid, data_byte, first_byte, last_byte, input ready);
	modport sink   (input valid, data_byte, first_byte, last_byte, output ready);
endinterface

interface npfp_pos_if;
	logic                                 valid;
	logic                                 ready;
	logic                                 position_valid;
	logic signed [npfp_pkg::LAT_W-1:0]    latitude_fix;
	logic signed [npfp_pkg::LON_W-1:0]    longitude_fix;
	logic [1:0]                           fail_cause;

	modport source (output valid, position_valid, latitude_fix, longitude_fix, fail_cause,
		input ready);
	modport sink   (input valid, position_valid, latitude_fix, longitude_fix, fail_cause,
		output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/nmea_position_field_parser.sv =====
// ============================================================================
// nmea_position_field_parser
// Parses latitude and longitude out of a GLL style position sentence chunk,
// one ASCII character per beat, into signed fixed point coordinates.
// ============================================================================
// The block takes one character beat per clock cycle with no gaps of its own:
// each beat goes into an input register and is then folded into the field state
// by one pass of logic (a multiply-by-ten accumulate, or on a comma the
// scaling of the field into 1/(60*10^FRACTION_DIGITS) degree). The last beat
// of a chunk waits in the input register until the output register is free;
// the result of the chunk is then loaded into the output register, which
// offers it as the result beat. Input beats are refused only when a last
// beat waits in the input register while the previous result has not been
// taken.
// A first beat restarts the parse; any beat after a result also starts a new
// chunk. Characters past MAX_BYTES are dropped, but their last mark counts.
`default_nettype none

module nmea_position_field_parser #(
	parameter int unsigned MAX_BYTES       = 64,
	parameter int unsigned FRACTION_DIGITS = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	npfp_char_if.sink  chars,
	npfp_pos_if.source position
);
	import npfp_pkg::*;

	localparam int unsigned     POS_W     = $clog2(MAX_BYTES + 1);
	localparam longint unsigned DEG_SCALE = 60 * pow10(FRACTION_DIGITS);
	localparam int unsigned     MAG_RAW_W = $clog2(255 * DEG_SCALE + (1 << MIN_W) + 1);
	localparam int unsigned     MAG_W     = (MAG_RAW_W > LON_W) ? MAG_RAW_W : LON_W;
	localparam logic [FC_W-1:0] FRAC_N    = FC_W'(FRACTION_DIGITS);
	localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(MAX_BYTES);

	// Input register
	logic              s1_valid;
	logic [CHAR_W-1:0] s1_char;
	logic              s1_first;
	logic              s1_last;
	logic              s1_go;

	// Parse state
	logic [POS_W-1:0]        pos_q;
	logic [FLD_W-1:0]        field_q;
	logic [CIF_W-1:0]        cif_q;
	logic                    point_q;
	logic [FC_W-1:0]         fc_q;
	logic [DEG_W-1:0]        deg_q;
	logic [MIN_W-1:0]        min_q;
	logic signed [LAT_W-1:0] lat_q;
	logic signed [LON_W-1:0] lon_q;
	logic                    complete_q;
	fail_cause_t             err_q;

	// Result register
	logic                    out_valid_q;
	logic                    pvalid_q;
	logic signed [LAT_W-1:0] lat_out_q;
	logic signed [LON_W-1:0] lon_out_q;
	fail_cause_t             cause_q;

	// Next state from the byte pass
	logic [POS_W-1:0]        n_pos;
	logic [FLD_W-1:0]        n_field;
	logic [CIF_W-1:0]        n_cif;
	logic                    n_point;
	logic [FC_W-1:0]         n_fc;
	logic [DEG_W-1:0]        n_deg;
	logic [MIN_W-1:0]        n_min;
	logic signed [LAT_W-1:0] n_lat;
	logic signed [LON_W-1:0] n_lon;
	logic                    n_complete;
	fail_cause_t             n_err;
	logic                    res_valid;
	fail_cause_t             res_cause;

	// Advance the input register unless a last beat waits on a full result
	assign s1_go        = s1_valid && (!s1_last || !out_valid_q || position.ready);
	assign chars.ready  = !s1_valid || s1_go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else if (chars.ready) begin
			s1_valid <= chars.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (chars.valid && chars.ready) begin
			s1_char  <= chars.data_byte;
			s1_first <= chars.first_byte;
			s1_last  <= chars.last_byte;
		end
	end

	// Fold one character into the parse state
	always_comb begin : byte_pass
		logic [POS_W-1:0]        b_pos;
		logic [FLD_W-1:0]        b_field;
		logic [CIF_W-1:0]        b_cif;
		logic                    b_point;
		logic [FC_W-1:0]         b_fc;
		logic [DEG_W-1:0]        b_deg;
		logic [MIN_W-1:0]        b_min;
		logic signed [LAT_W-1:0] b_lat;
		logic signed [LON_W-1:0] b_lon;
		logic                    b_complete;
		fail_cause_t             b_err;
		logic [FC_W-1:0]         pad;
		logic [2*MIN_W-1:0]      min_wide;
		logic [MIN_W-1:0]        min_cap;
		logic [MAG_W-1:0]        mag;
		logic [LAT_W-2:0]        lat_mag;
		logic [LON_W-2:0]        lon_mag;
		logic                    is_digit;
		logic [3:0]              dig;
		logic [DEG_W+3:0]        deg10;
		logic [MIN_W+3:0]        min10;
		logic [CIF_W-1:0]        deg_digits;

		// A first mark clears the state before the byte
		b_pos      = s1_first ? '0 : pos_q;
		b_field    = s1_first ? '0 : field_q;
		b_cif      = s1_first ? '0 : cif_q;
		b_point    = s1_first ? 1'b0 : point_q;
		b_fc       = s1_first ? '0 : fc_q;
		b_deg      = s1_first ? '0 : deg_q;
		b_min      = s1_first ? '0 : min_q;
		b_lat      = s1_first ? '0 : lat_q;
		b_lon      = s1_first ? '0 : lon_q;
		b_complete = s1_first ? 1'b0 : complete_q;
		b_err      = s1_first ? FAIL_NONE : err_q;

		// Scale the finished field: degrees * 60 * 10^F plus padded minutes
		pad      = (b_fc < FRAC_N) ? FRAC_N - b_fc : '0;
		min_wide = (2*MIN_W)'(b_min) * (2*MIN_W)'(pow10_small(pad));
		min_cap  = (min_wide > (2*MIN_W)'(MIN_MAX)) ? MIN_MAX : min_wide[MIN_W-1:0];
		mag      = MAG_W'(b_deg) * MAG_W'(DEG_SCALE) + MAG_W'(min_cap);
		lat_mag  = (mag > MAG_W'(LAT_MAG_MAX)) ? LAT_MAG_MAX : mag[LAT_W-2:0];
		lon_mag  = (mag > MAG_W'(LON_MAG_MAX)) ? LON_MAG_MAX : mag[LON_W-2:0];

		// Digit accumulate with saturation
		is_digit   = (s1_char >= CHAR_0) && (s1_char <= CHAR_9);
		dig        = is_digit ? s1_char[3:0] : 4'd0;
		deg10      = (DEG_W+4)'(b_deg) * (DEG_W+4)'(10) + (DEG_W+4)'(dig);
		min10      = (MIN_W+4)'(b_min) * (MIN_W+4)'(10) + (MIN_W+4)'(dig);
		deg_digits = (b_field == FIELD_LAT) ? LAT_DEG_DIGITS : LON_DEG_DIGITS;

		n_pos      = b_pos;
		n_field    = b_field;
		n_cif      = b_cif;
		n_point    = b_point;
		n_fc       = b_fc;
		n_deg      = b_deg;
		n_min      = b_min;
		n_lat      = b_lat;
		n_lon      = b_lon;
		n_complete = b_complete;
		n_err      = b_err;

		if (b_pos < POS_LIMIT) begin
			// Check the sentence head; first error wins
			if (b_pos == '0 && s1_char != CHAR_N && n_err == FAIL_NONE) begin
				n_err = FAIL_START;
			end
			if (b_pos == POS_W'(1) && s1_char == CHAR_T && n_err == FAIL_NONE) begin
				n_err = FAIL_TEXT;
			end

			if (s1_char == CHAR_COMMA) begin
				// Close the field
				if (b_field == FIELD_LAT) begin
					if (b_cif < LAT_DEG_DIGITS && n_err == FAIL_NONE) begin
						n_err = FAIL_FIELD;
					end
					n_lat = signed'({1'b0, lat_mag});
				end else if (b_field == FIELD_LON) begin
					n_lon      = signed'({1'b0, lon_mag});
					n_complete = 1'b1;
				end
				if (b_field != FIELD_MAX) begin
					n_field = b_field + FLD_W'(1);
				end
				n_cif   = '0;
				n_point = 1'b0;
				n_fc    = '0;
				n_deg   = '0;
				n_min   = '0;
			end else begin
				if (b_field == FIELD_LAT || b_field == FIELD_LON) begin
					// Degrees, then minutes with an optional point
					if (b_cif < deg_digits) begin
						n_deg = (deg10 > (DEG_W+4)'(DEG_MAX)) ? DEG_MAX : deg10[DEG_W-1:0];
					end else if (s1_char == CHAR_POINT && !b_point) begin
						n_point = 1'b1;
					end else if (is_digit && (!b_point || b_fc < FRAC_N)) begin
						n_min = (min10 > (MIN_W+4)'(MIN_MAX)) ? MIN_MAX : min10[MIN_W-1:0];
						if (b_point) begin
							n_fc = b_fc + FC_W'(1);
						end
					end
				end else if (b_field == FIELD_LAT_SIGN && b_cif == '0 && s1_char == CHAR_S) begin
					n_lat = -b_lat;
				end else if (b_field == FIELD_LON_SIGN && b_cif == '0
						&& s1_char == CHAR_W_UP) begin
					n_lon = -b_lon;
				end
				if (b_cif != CIF_MAX) begin
					n_cif = b_cif + CIF_W'(1);
				end
			end
			n_pos = b_pos + POS_W'(1);
		end

		// Result on the last byte
		res_valid = (n_err == FAIL_NONE) && n_complete;
		if (n_err != FAIL_NONE) begin
			res_cause = n_err;
		end else if (n_complete) begin
			res_cause = FAIL_NONE;
		end else begin
			res_cause = FAIL_FIELD;
		end
	end

	// Hold the parse state; clear it after a last byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= '0;
			field_q    <= '0;
			cif_q      <= '0;
			point_q    <= 1'b0;
			fc_q       <= '0;
			deg_q      <= '0;
			min_q      <= '0;
			lat_q      <= '0;
			lon_q      <= '0;
			complete_q <= 1'b0;
			err_q      <= FAIL_NONE;
		end else if (s1_go) begin
			if (s1_last) begin
				pos_q      <= '0;
				field_q    <= '0;
				cif_q      <= '0;
				point_q    <= 1'b0;
				fc_q       <= '0;
				deg_q      <= '0;
				min_q      <= '0;
				lat_q      <= '0;
				lon_q      <= '0;
				complete_q <= 1'b0;
				err_q      <= FAIL_NONE;
			end else begin
				pos_q      <= n_pos;
				field_q    <= n_field;
				cif_q      <= n_cif;
				point_q    <= n_point;
				fc_q       <= n_fc;
				deg_q      <= n_deg;
				min_q      <= n_min;
				lat_q      <= n_lat;
				lon_q      <= n_lon;
				complete_q <= n_complete;
				err_q      <= n_err;
			end
		end
	end

	// Result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_go && s1_last) begin
			out_valid_q <= 1'b1;
		end else if (position.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result register payload
	always_ff @(posedge clk) begin
		if (s1_go && s1_last) begin
			pvalid_q  <= res_valid;
			lat_out_q <= res_valid ? n_lat : '0;
			lon_out_q <= res_valid ? n_lon : '0;
			cause_q   <= res_cause;
		end
	end

	assign position.valid          = out_valid_q;
	assign position.position_valid = pvalid_q;
	assign position.latitude_fix   = lat_out_q;
	assign position.longitude_fix  = lon_out_q;
	assign position.fail_cause     = cause_q;

endmodule

`default_nettype wire

// ===== hw/rtl/npfp_checker.sv =====
// ============================================================================
// npfp_checker
// Port level checks on the position sentence field parser, bound to the
// top level.
// ============================================================================
`default_nettype none

module npfp_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              chars_valid,
	input logic                              chars_ready,
	input logic                              chars_last_byte,
	input logic                              pos_valid,
	input logic                              pos_ready,
	input logic                              pos_position_valid,
	input logic signed [npfp_pkg::LAT_W-1:0] pos_latitude_fix,
	input logic signed [npfp_pkg::LON_W-1:0] pos_longitude_fix,
	input logic [1:0]                        pos_fail_cause
);
	import npfp_pkg::*;

	// Hold a stalled result beat
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(pos_valid && !pos_ready) |=> (pos_valid && $stable(pos_position_valid)
			&& $stable(pos_latitude_fix) && $stable(pos_longitude_fix)
			&& $stable(pos_fail_cause)))
		else $error("result beat changed while stalled");

	// A good position carries no fail cause, and no cause means a good position
	a_valid_cause: assert property (@(posedge clk) disable iff (!arst_n)
		pos_valid |-> (pos_position_valid == (pos_fail_cause == FAIL_NONE)))
		else $error("position_valid disagrees with fail_cause");

	// A failed chunk gives zero coordinates
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(pos_valid && !pos_position_valid) |-> (pos_latitude_fix == '0
			&& pos_longitude_fix == '0))
		else $error("coordinates not cleared on a failed chunk");

	// A fresh result comes from a last beat accepted earlier through the input register
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(pos_valid) |-> $past(chars_valid && chars_ready && chars_last_byte, 2))
		else $error("result without a preceding last beat");

endmodule

bind nmea_position_field_parser npfp_checker u_npfp_checker (
	.clk                (clk),
	.arst_n             (arst_n),
	.chars_valid        (chars.valid),
	.chars_ready        (chars.ready),
	.chars_last_byte    (chars.last_byte),
	.pos_valid          (position.valid),
	.pos_ready          (position.ready),
	.pos_position_valid (position.position_valid),
	.pos_latitude_fix   (position.latitude_fix),
	.pos_longitude_fix  (position.longitude_fix),
	.pos_fail_cause     (position.fail_cause)
);

`default_nettype wire

// ===== tb/tb_nmea_position_field_parser.sv =====
// ----------------------------------------------------------------------------
// tb_nmea_position_field_parser
// Self-checking bench for the position sentence field parser: a short table
// of hand-made chunks, then random sentences, broken sentences and noise
// under three idle patterns. Each result beat is checked against the table
// entry where the table gives one, else against a local fixed point parser that tracks the chunk state beat by beat.
// ----------------------------------------------------------------------------
module tb_nmea_position_field_parser;
	timeunit 1ns;
	timeprecision 1ps;

	import npfp_pkg::*;

	localparam int unsigned MAX_CHARS   = 64;
	localparam int unsigned FRAC_DIGITS = 4;
	localparam longint unsigned FRAC_SCALE = 10 ** FRAC_DIGITS;
	localparam logic [CHAR_W-1:0] CHAR_E = 8'h45;

	typedef struct packed {
		logic                    position_valid;
		logic signed [LAT_W-1:0] latitude_fix;
		logic signed [LON_W-1:0] longitude_fix;
		fail_cause_t             fail_cause;
	} position_t;

	typedef struct packed {
		logic [CHAR_W-1:0] c;
		logic              first;
		logic              last;
		logic              typed;
		position_t         want;
	} char_row_t;

	localparam position_t NO_FIX    = '0;
	localparam position_t BAD_START = '{1'b0, 27'sd0, 28'sd0, FAIL_START};
	localparam position_t BAD_TEXT  = '{1'b0, 27'sd0, 28'sd0, FAIL_TEXT};
	localparam position_t BAD_FIELD = '{1'b0, 27'sd0, 28'sd0, FAIL_FIELD};

	localparam int unsigned OPENING_LEN = 22;
	localparam char_row_t OPENING_ROWS [OPENING_LEN] = '{
		// bad start byte, single beat chunk
		'{8'h00,      1'b1, 1'b1, 1'b1, BAD_START},
		// text message, started without a first mark right after a result
		'{CHAR_N,     1'b0, 1'b0, 1'b0, NO_FIX},
		'{CHAR_T,     1'b0, 1'b1, 1'b1, BAD_TEXT},
		// chunk ends before the longitude field is closed
		'{CHAR_N,     1'b1, 1'b1, 1'b1, BAD_FIELD},
		// latitude field shorter than two characters
		'{CHAR_N,     1'b1, 1'b0, 1'b0, NO_FIX},
		'{CHAR_COMMA, 1'b0, 1'b0, 1'b0, NO_FIX},
		'{CHAR_9,     1'b0, 1'b0, 1'b0, NO_FIX},
		'{CHAR_COMMA, 1'b0, 1'b1, 1'b1, BAD_FIELD},
		// south and west, saturated longitude degrees, odd character skipped
		'{CHAR_N,     1'b1, 1'b0, 1'b0, NO_FIX},
		'{CHAR_COMMA, 1'b0, 1'b0, 1'b0, NO_FIX},
		'{CHAR_9,     1'b0, 1'b0, 1'b0, NO_FIX},
		'{CHAR_9,     1'b0, 1'b0, 1'b0, NO_FIX},
		'{CHAR_POINT, 1'b0, 1'b0, 1'b0, NO_FIX},
		'{CHAR_COMMA, 1'b0, 1'b0, 1'b0, NO_FIX},
		'{CHAR_S,     1'b0, 1'b0, 1'b0, NO_FIX},
		'{CHAR_COMMA, 1'b0, 1'b0, 1'b0, NO_FIX},
		'{CHAR_9,     1'b0, 1'b0, 1'b0, NO_FIX},
		'{CHAR_9,     1'b0, 1'b0, 1'b0, NO_FIX},
		'{CHAR_9,     1'b0, 1'b0, 1'b0, NO_FIX},
		'{8'hFF,      1'b0, 1'b0, 1'b0, NO_FIX},
		'{CHAR_COMMA, 1'b0, 1'b0, 1'b0, NO_FIX},
		'{CHAR_W_UP,  1'b0, 1'b1, 1'b0, NO_FIX}
	};

	logic clk;
	logic arst_n;

	npfp_char_if char_ch ();
	npfp_pos_if  pos_ch ();

	nmea_position_field_parser #(
		.MAX_BYTES      (MAX_CHARS),
		.FRACTION_DIGITS(FRAC_DIGITS)
	) i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.chars   (char_ch),
		.position(pos_ch)
	);

	// Parser state as the block should hold it
	logic [6:0]        byte_pos;
	logic [FLD_W-1:0]  field_no;
	logic [CIF_W-1:0]  char_cnt;
	logic              seen_pt;
	logic [FC_W-1:0]   frac_cnt;
	logic [DEG_W-1:0]  deg_acc;
	logic [MIN_W-1:0]  min_acc;
	logic signed [LAT_W-1:0] lat_held;
	logic signed [LON_W-1:0] lon_held;
	logic              fields_done;
	fail_cause_t       parse_err;

	position_t         pending_fixes [$];
	logic [CHAR_W-1:0] chunk_bytes [$];

	int unsigned gap_pct;
	int unsigned stall_pct;
	int unsigned chars_parsed;
	int unsigned fixes_checked;
	int unsigned sentences_sent;
	int unsigned noise_bursts;
	int unsigned mismatches;

	// Clock
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Hard stop
	initial begin
		#5_000_000;
		$display("TB_ERROR");
		$finish;
	end

	task automatic clear_field();
		char_cnt = '0;
		seen_pt  = 1'b0;
		frac_cnt = '0;
		deg_acc  = '0;
		min_acc  = '0;
	endtask

	task automatic clear_parse();
		byte_pos    = '0;
		field_no    = '0;
		clear_field();
		lat_held    = '0;
		lon_held    = '0;
		fields_done = 1'b0;
		parse_err   = FAIL_NONE;
	endtask

	// Scale the current field to 1/(60*10^F) degree, padding missing fraction digits
	function automatic longint unsigned field_magnitude(input longint unsigned limit);
		longint unsigned mins;
		longint unsigned mag;
		mins = min_acc;
		for (int i = frac_cnt; i < FRAC_DIGITS; i++)
			mins = mins * 10;
		if (mins > MIN_MAX)
			mins = MIN_MAX;
		mag = longint'(deg_acc) * 60 * FRAC_SCALE + mins;
		if (mag > limit)
			mag = limit;
		return mag;
	endfunction

	// Fold one coordinate character into degrees or minutes
	task automatic take_coord_char(input logic [CHAR_W-1:0] c, input logic [CIF_W-1:0] deg_digits);
		logic            is_digit;
		int unsigned     d;
		longint unsigned acc;
		is_digit = (c >= CHAR_0) && (c <= CHAR_9);
		d = is_digit ? int'(c - CHAR_0) : 0;
		if (char_cnt < deg_digits) begin
			acc = longint'(deg_acc) * 10 + d;
			deg_acc = (acc > DEG_MAX) ? DEG_MAX : acc[DEG_W-1:0];
		end else if (c == CHAR_POINT && !seen_pt) begin
			seen_pt = 1'b1;
		end else if (is_digit && (!seen_pt || frac_cnt < FRAC_DIGITS)) begin
			acc = longint'(min_acc) * 10 + d;
			min_acc = (acc > MIN_MAX) ? MIN_MAX : acc[MIN_W-1:0];
			if (seen_pt)
				frac_cnt++;
		end
	endtask

	// Advance the parse by one accepted beat; give the position on a last mark
	task automatic parse_char(input logic [CHAR_W-1:0] c, input logic f, input logic l,
		output logic got, output position_t fix);
		logic ok;
		got = 1'b0;
		fix = '0;
		if (f)
			clear_parse();
		if (byte_pos < MAX_CHARS) begin
			chars_parsed++;
			if (byte_pos == 0 && c != CHAR_N && parse_err == FAIL_NONE)
				parse_err = FAIL_START;
			if (byte_pos == 1 && c == CHAR_T && parse_err == FAIL_NONE)
				parse_err = FAIL_TEXT;
			if (c == CHAR_COMMA) begin
				if (field_no == FIELD_LAT) begin
					if (char_cnt < 2 && parse_err == FAIL_NONE)
						parse_err = FAIL_FIELD;
					lat_held = LAT_W'(field_magnitude(LAT_MAG_MAX));
				end else if (field_no == FIELD_LON) begin
					lon_held = LON_W'(field_magnitude(LON_MAG_MAX));
					fields_done = 1'b1;
				end
				if (field_no != FIELD_MAX)
					field_no++;
				clear_field();
			end else begin
				if (field_no == FIELD_LAT)
					take_coord_char(c, LAT_DEG_DIGITS);
				else if (field_no == FIELD_LON)
					take_coord_char(c, LON_DEG_DIGITS);
				else if (field_no == FIELD_LAT_SIGN && char_cnt == 0 && c == CHAR_S)
					lat_held = -lat_held;
				else if (field_no == FIELD_LON_SIGN && char_cnt == 0 && c == CHAR_W_UP)
					lon_held = -lon_held;
				if (char_cnt != CIF_MAX)
					char_cnt++;
			end
			byte_pos++;
		end
		if (l) begin
			ok = (parse_err == FAIL_NONE) && fields_done;
			got = 1'b1;
			fix.position_valid = ok;
			fix.latitude_fix   = ok ? lat_held : '0;
			fix.longitude_fix  = ok ? lon_held : '0;
			fix.fail_cause     = (parse_err != FAIL_NONE) ? parse_err :
				(fields_done ? FAIL_NONE : FAIL_FIELD);
			clear_parse();
		end
	endtask

	// Drive one beat, wait for it to be taken, record what it should produce
	task automatic put_char(input logic [CHAR_W-1:0] c, input logic f, input logic l,
		input logic typed, input position_t want);
		logic      got;
		position_t fix;
		while ($urandom_range(99) < gap_pct) begin
			char_ch.valid <= 1'b0;
			@(posedge clk);
		end
		char_ch.valid      <= 1'b1;
		char_ch.data_byte  <= c;
		char_ch.first_byte <= f;
		char_ch.last_byte  <= l;
		do @(posedge clk); while (!char_ch.ready);
		parse_char(c, f, l, got, fix);
		if (got)
			pending_fixes.push_back(typed ? want : fix);
	endtask

	function automatic logic [CHAR_W-1:0] odd_char();
		logic [CHAR_W-1:0] b;
		b = CHAR_W'($urandom_range(255));
		return (b == CHAR_COMMA) ? CHAR_POINT : b;
	endfunction

	task automatic push_digits(input int unsigned count);
		repeat (count) chunk_bytes.push_back(CHAR_0 + CHAR_W'($urandom_range(9)));
	endtask

	task automatic push_text(input string s);
		for (int i = 0; i < s.len(); i++)
			chunk_bytes.push_back(s[i]);
	endtask

	// Coordinate field: mostly well formed, sometimes empty, short or odd
	task automatic push_coord(input int unsigned deg_digits);
		int unsigned kind;
		kind = $urandom_range(15);
		if (kind == 0)
			return;
		if (kind == 1) begin
			push_digits(1);
			return;
		end
		if (kind == 2) begin
			chunk_bytes.push_back(odd_char());
			push_digits(deg_digits - 1);
		end else begin
			push_digits(deg_digits);
		end
		push_digits(kind == 3 ? $urandom_range(5, 8) : $urandom_range(0, 2));
		if ($urandom_range(3) != 0) begin
			chunk_bytes.push_back(CHAR_POINT);
			push_digits($urandom_range(0, 6));
		end
		if (kind == 4) begin
			chunk_bytes.push_back(odd_char());
			push_digits($urandom_range(0, 3));
		end
	endtask

	task automatic push_sign(input logic [CHAR_W-1:0] pos_c, input logic [CHAR_W-1:0] neg_c);
		int unsigned r;
		r = $urandom_range(7);
		if (r == 1) begin
			chunk_bytes.push_back(odd_char());
			chunk_bytes.push_back(neg_c);
		end else if (r >= 2 && r <= 4) begin
			chunk_bytes.push_back(pos_c);
		end else if (r >= 5) begin
			chunk_bytes.push_back(neg_c);
		end
	endtask

	// Build one sentence chunk with random content, maybe cut short or overlong
	task automatic send_sentence();
		int unsigned r;
		int unsigned keep;
		logic        mark_first;
		chunk_bytes.delete();
		r = $urandom_range(15);
		chunk_bytes.push_back(r == 0 ? odd_char() : CHAR_N);
		if (r == 1)
			push_text("TXT");
		else
			push_text("GLL");
		chunk_bytes.push_back(CHAR_COMMA);
		push_coord(LAT_DEG_DIGITS);
		chunk_bytes.push_back(CHAR_COMMA);
		push_sign(CHAR_N, CHAR_S);
		chunk_bytes.push_back(CHAR_COMMA);
		push_coord(LON_DEG_DIGITS);
		chunk_bytes.push_back(CHAR_COMMA);
		push_sign(CHAR_E, CHAR_W_UP);
		if ($urandom_range(1) != 0)
			push_text(",123519,A");
		if ($urandom_range(11) == 0)
			repeat ($urandom_range(40, 80)) chunk_bytes.push_back(odd_char());
		if ($urandom_range(5) == 0) begin
			keep = $urandom_range(1, chunk_bytes.size());
			while (chunk_bytes.size() > keep)
				void'(chunk_bytes.pop_back());
		end
		mark_first = ($urandom_range(7) != 0);
		foreach (chunk_bytes[i])
			put_char(chunk_bytes[i], mark_first && i == 0, i == chunk_bytes.size() - 1,
				1'b0, NO_FIX);
		sentences_sent++;
	endtask

	task automatic compare_field(input string name, input longint want, input longint got);
		if (want != got) begin
			mismatches++;
			$display("%0t: %s expected %0d actual %0d", $time, name, want, got);
		end
	endtask

	// Result side: take beats with random stalls and check each one
	initial begin
		position_t want;
		pos_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (pos_ch.valid && pos_ch.ready) begin
				if (pending_fixes.size() == 0) begin
					mismatches++;
					$display("%0t: unexpected position beat, expected none, actual fail_cause %0d",
						$time, pos_ch.fail_cause);
				end else begin
					want = pending_fixes.pop_front();
					fixes_checked++;
					compare_field("position_valid", want.position_valid, pos_ch.position_valid);
					compare_field("latitude_fix", want.latitude_fix, pos_ch.latitude_fix);
					compare_field("longitude_fix", want.longitude_fix, pos_ch.longitude_fix);
					compare_field("fail_cause", want.fail_cause, pos_ch.fail_cause);
				end
			end
			pos_ch.ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// Character side: reset, table, random phases, drain
	initial begin
		int unsigned target;
		int unsigned len;
		arst_n             <= 1'b0;
		char_ch.valid      <= 1'b0;
		char_ch.data_byte  <= '0;
		char_ch.first_byte <= 1'b0;
		char_ch.last_byte  <= 1'b0;
		clear_parse();
		pending_fixes.delete();
		chars_parsed   = 0;
		fixes_checked  = 0;
		sentences_sent = 0;
		noise_bursts   = 0;
		mismatches     = 0;
		gap_pct        = 9;
		stall_pct      = 85;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Hand-made chunks
		for (int i = 0; i < OPENING_LEN; i++)
			put_char(OPENING_ROWS[i].c, OPENING_ROWS[i].first, OPENING_ROWS[i].last,
				OPENING_ROWS[i].typed, OPENING_ROWS[i].want);

		// Random traffic: receiver sparse, then sender sparse, then full rate
		for (int phase = 0; phase < 3; phase++) begin
			gap_pct   = (phase == 0) ? 9 : (phase == 1) ? 85 : 0;
			stall_pct = (phase == 0) ? 85 : (phase == 1) ? 9 : 0;
			target = chars_parsed + 400;
			while (chars_parsed < target) begin
				if ($urandom_range(9) == 0) begin
					len = $urandom_range(1, 12);
					repeat (len)
						put_char(CHAR_W'($urandom_range(255)), $urandom_range(7) == 0,
							$urandom_range(5) == 0, 1'b0, NO_FIX);
					noise_bursts++;
				end else begin
					send_sentence();
				end
			end
		end
		char_ch.valid <= 1'b0;

		// Drain outstanding results, then watch for strays
		while (pending_fixes.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		$display("Checked %0d position results over %0d parsed characters", fixes_checked,
			chars_parsed);
		$display("Sent %0d sentence chunks and %0d noise bursts under three idle patterns",
			sentences_sent, noise_bursts);
		if (mismatches == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

// ===== nmea_position_field_parser.f =====
hw/rtl/npfp_pkg.sv
hw/rtl/npfp_if.sv
hw/rtl/nmea_position_field_parser.sv
hw/rtl/npfp_checker.sv
tb/tb_nmea_position_field_parser.sv
